/* sv/ihmt_pkg.sv */
// ----------------------------------------------------------------------------
// ihmt_pkg
// Types, codes and reset values shared by the membership timer block.
// ----------------------------------------------------------------------------
package ihmt_pkg;

  localparam int GROUP_BITS = 32;
  localparam int IFACE_BITS = 4;
  localparam int MASK_BITS  = 6;
  localparam int SEED_BITS  = 16;
  localparam int CMD_BITS   = 3;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  localparam int TABLE_DEPTH_DEFAULT = 32;
  localparam int TIMER_BITS_DEFAULT  = 6;

  localparam logic [GROUP_BITS-1:0] ALL_HOSTS_RESET = 32'hE000_0001;
  localparam logic [IFACE_BITS-1:0] LOOPBACK_RESET  = 4'd0;
  localparam logic [MASK_BITS-1:0]  MASK_RESET      = 6'd63;
  localparam logic [SEED_BITS-1:0]  SEED_RESET      = 16'd44257;
  localparam logic [SEED_BITS-1:0]  LFSR_TAPS       = 16'hB400;
  localparam logic [3:0]            CLASS_D_PREFIX  = 4'hE;

  localparam logic [CMD_BITS-1:0] CMD_JOIN   = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_LEAVE  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_QUERY  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_REPORT = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_TICK   = 3'd4;

  localparam logic [1:0] REG_ALL_HOSTS = 2'd0;
  localparam logic [1:0] REG_LOOPBACK  = 2'd1;
  localparam logic [1:0] REG_MASK      = 2'd2;
  localparam logic [1:0] REG_SEED      = 2'd3;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_LOOPBACK  = 3'd1,
    STAT_BAD_QUERY = 3'd2,
    STAT_BAD_REPORT = 3'd3,
    STAT_BAD_PACKET = 3'd4,
    STAT_FULL      = 3'd5,
    STAT_NOT_FOUND = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic [GROUP_BITS-1:0] group_addr;
    logic [GROUP_BITS-1:0] dest_addr;
    logic [IFACE_BITS-1:0] iface;
    logic                  packet_ok;
  } cmd_t;

  typedef struct packed {
    logic                  report_valid;
    logic [GROUP_BITS-1:0] report_group;
    logic [IFACE_BITS-1:0] report_iface;
    logic [2:0]            status;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [GROUP_BITS-1:0] all_hosts_group;
    logic [IFACE_BITS-1:0] loopback_iface;
    logic [MASK_BITS-1:0]  delay_mask;
    logic                  seed_load;
    logic [SEED_BITS-1:0]  seed_value;
  } cfg_t;

endpackage

/* sv/ihmt_regs.sv */
// ----------------------------------------------------------------------------
// ihmt_regs
// APB-style configuration registers; a seed write also reloads the generator.
// ----------------------------------------------------------------------------
module ihmt_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ihmt_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [ihmt_pkg::DATA_BITS-1:0]  pwdata,
  output logic [ihmt_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  output ihmt_pkg::cfg_t                  cfg
);

  logic [ihmt_pkg::GROUP_BITS-1:0] all_hosts_group;
  logic [ihmt_pkg::IFACE_BITS-1:0] loopback_iface;
  logic [ihmt_pkg::MASK_BITS-1:0]  delay_mask;
  logic [ihmt_pkg::SEED_BITS-1:0]  random_seed;
  logic                            wr_strobe;
  logic [1:0]                      reg_index;

  assign pready    = 1'b1;
  assign wr_strobe = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      all_hosts_group <= ihmt_pkg::ALL_HOSTS_RESET;
      loopback_iface  <= ihmt_pkg::LOOPBACK_RESET;
      delay_mask      <= ihmt_pkg::MASK_RESET;
      random_seed     <= ihmt_pkg::SEED_RESET;
    end else if (wr_strobe) begin
      unique case (reg_index)
        ihmt_pkg::REG_ALL_HOSTS: all_hosts_group <= pwdata;
        ihmt_pkg::REG_LOOPBACK:  loopback_iface  <= pwdata[ihmt_pkg::IFACE_BITS-1:0];
        ihmt_pkg::REG_MASK:      delay_mask      <= pwdata[ihmt_pkg::MASK_BITS-1:0];
        ihmt_pkg::REG_SEED:      random_seed     <= pwdata[ihmt_pkg::SEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      ihmt_pkg::REG_ALL_HOSTS: prdata = all_hosts_group;
      ihmt_pkg::REG_LOOPBACK:  prdata = 32'(loopback_iface);
      ihmt_pkg::REG_MASK:      prdata = 32'(delay_mask);
      ihmt_pkg::REG_SEED:      prdata = 32'(random_seed);
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    cfg.all_hosts_group = all_hosts_group;
    cfg.loopback_iface  = loopback_iface;
    cfg.delay_mask      = delay_mask;
    cfg.seed_load       = wr_strobe && (reg_index == ihmt_pkg::REG_SEED);
    cfg.seed_value      = pwdata[ihmt_pkg::SEED_BITS-1:0];
  end

endmodule

/* sv/ihmt_table_mem.sv */
// ----------------------------------------------------------------------------
// ihmt_table_mem
// Membership entry memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ihmt_table_mem #(
  parameter int DEPTH = ihmt_pkg::TABLE_DEPTH_DEFAULT,
  parameter int WIDTH = 36 + ihmt_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/ihmt_seq.sv */
// ----------------------------------------------------------------------------
// ihmt_seq
// Command sequencer: walks the entry memory at most once per item, read-modify-write,
// holds valid bits, the delay generator and the result register.
// ----------------------------------------------------------------------------
module ihmt_seq #(
  parameter int TABLE_DEPTH = ihmt_pkg::TABLE_DEPTH_DEFAULT,
  parameter int TIMER_BITS  = ihmt_pkg::TIMER_BITS_DEFAULT,
  parameter int AW          = $clog2(TABLE_DEPTH),
  parameter int EW          = ihmt_pkg::GROUP_BITS + ihmt_pkg::IFACE_BITS + TIMER_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  ihmt_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  ihmt_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output ihmt_pkg::res_t res,
  output logic           mem_wr_en,
  output logic [AW-1:0]  mem_wr_addr,
  output logic [EW-1:0]  mem_wr_data,
  output logic           mem_rd_en,
  output logic [AW-1:0]  mem_rd_addr,
  input  logic [EW-1:0]  mem_rd_data
);

  localparam int DW = (TIMER_BITS > ihmt_pkg::MASK_BITS) ? TIMER_BITS + 1
                                                         : ihmt_pkg::MASK_BITS + 1;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [AW-1:0]         LAST_IDX  = AW'(TABLE_DEPTH - 1);

  ihmt_pkg::state_t  state, state_next;
  ihmt_pkg::cmd_t    cur, cur_next;
  ihmt_pkg::status_t status_q, status_next;
  ihmt_pkg::res_t    out_data, out_data_next;
  logic [AW-1:0]     idx, idx_next;
  logic [AW-1:0]     free_idx, free_idx_next;
  logic              found, found_next;
  logic              free_found, free_found_next;
  logic              hold_valid, hold_valid_next;
  logic [ihmt_pkg::GROUP_BITS-1:0] hold_group, hold_group_next;
  logic [ihmt_pkg::IFACE_BITS-1:0] hold_iface, hold_iface_next;
  logic              running, running_next;
  logic [ihmt_pkg::SEED_BITS-1:0] lfsr, lfsr_next, lfsr_step;
  logic [TABLE_DEPTH-1:0] valid_bits, valid_next;
  logic              out_valid, out_valid_next;

  logic              out_free;
  logic [DW-1:0]     draw_wide;
  logic [TIMER_BITS-1:0] draw;
  logic [ihmt_pkg::GROUP_BITS-1:0] e_group;
  logic [ihmt_pkg::IFACE_BITS-1:0] e_iface;
  logic [TIMER_BITS-1:0] e_timer, e_timer_dec;
  logic              e_valid, e_match, scan_needed;
  ihmt_pkg::status_t pre_status;

  function automatic ihmt_pkg::res_t make_res(
    input logic                            rv,
    input logic [ihmt_pkg::GROUP_BITS-1:0] grp,
    input logic [ihmt_pkg::IFACE_BITS-1:0] ifc,
    input ihmt_pkg::status_t               st,
    input logic                            lst
  );
    ihmt_pkg::res_t r;
    r.report_valid = rv;
    r.report_group = rv ? grp : '0;
    r.report_iface = rv ? ifc : '0;
    r.status       = st;
    r.last         = lst;
    return r;
  endfunction

  assign cmd_ready = (state == ihmt_pkg::S_IDLE);
  assign res_valid = out_valid;
  assign res       = out_data;
  assign out_free  = !out_valid || res_ready;

  assign draw_wide = DW'(cfg.delay_mask & lfsr[ihmt_pkg::MASK_BITS-1:0]) + DW'(1);
  assign draw      = (draw_wide > DW'(TIMER_MAX)) ? TIMER_MAX : draw_wide[TIMER_BITS-1:0];
  assign lfsr_step = {1'b0, lfsr[ihmt_pkg::SEED_BITS-1:1]}
                   ^ (lfsr[0] ? ihmt_pkg::LFSR_TAPS : '0);

  assign e_timer     = mem_rd_data[TIMER_BITS-1:0];
  assign e_iface     = mem_rd_data[TIMER_BITS +: ihmt_pkg::IFACE_BITS];
  assign e_group     = mem_rd_data[EW-1 -: ihmt_pkg::GROUP_BITS];
  assign e_timer_dec = e_timer - TIMER_BITS'(1);
  assign e_valid     = valid_bits[idx];
  assign e_match     = e_valid && (e_group == cur.group_addr) && (e_iface == cur.iface);

  always_comb begin
    pre_status  = ihmt_pkg::STAT_OK;
    scan_needed = 1'b0;
    case (cmd.command)
      ihmt_pkg::CMD_JOIN, ihmt_pkg::CMD_LEAVE: begin
        scan_needed = 1'b1;
      end
      ihmt_pkg::CMD_QUERY: begin
        if (!cmd.packet_ok) begin
          pre_status = ihmt_pkg::STAT_BAD_PACKET;
        end else if (cmd.iface == cfg.loopback_iface) begin
          pre_status = ihmt_pkg::STAT_LOOPBACK;
        end else if (cmd.dest_addr != cfg.all_hosts_group) begin
          pre_status = ihmt_pkg::STAT_BAD_QUERY;
        end else begin
          scan_needed = 1'b1;
        end
      end
      ihmt_pkg::CMD_REPORT: begin
        if (!cmd.packet_ok) begin
          pre_status = ihmt_pkg::STAT_BAD_PACKET;
        end else if (cmd.iface == cfg.loopback_iface) begin
          pre_status = ihmt_pkg::STAT_LOOPBACK;
        end else if ((cmd.group_addr[31:28] != ihmt_pkg::CLASS_D_PREFIX) ||
                     (cmd.group_addr != cmd.dest_addr)) begin
          pre_status = ihmt_pkg::STAT_BAD_REPORT;
        end else begin
          scan_needed = 1'b1;
        end
      end
      ihmt_pkg::CMD_TICK: begin
        scan_needed = running;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    status_next     = status_q;
    idx_next        = idx;
    free_idx_next   = free_idx;
    found_next      = found;
    free_found_next = free_found;
    hold_valid_next = hold_valid;
    hold_group_next = hold_group;
    hold_iface_next = hold_iface;
    running_next    = running;
    lfsr_next       = lfsr;
    valid_next      = valid_bits;
    out_valid_next  = out_valid && !res_ready;
    out_data_next   = out_data;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = '0;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = idx;
    mem_wr_data     = {e_group, e_iface, e_timer};

    unique case (state)
      ihmt_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cur_next        = cmd;
          status_next     = pre_status;
          idx_next        = '0;
          found_next      = 1'b0;
          free_found_next = 1'b0;
          hold_valid_next = 1'b0;
          mem_rd_en       = 1'b1;
          if ((cmd.command == ihmt_pkg::CMD_TICK) && running) begin
            running_next = 1'b0;
          end
          state_next = scan_needed ? ihmt_pkg::S_SCAN : ihmt_pkg::S_DONE;
        end
      end

      ihmt_pkg::S_SCAN: begin
        logic stall;
        stall = 1'b0;
        case (cur.command)
          ihmt_pkg::CMD_JOIN: begin
            if (e_match) begin
              found_next = 1'b1;
            end
            if (!e_valid && !free_found) begin
              free_found_next = 1'b1;
              free_idx_next   = idx;
            end
          end
          ihmt_pkg::CMD_LEAVE: begin
            if (e_match) begin
              found_next      = 1'b1;
              valid_next[idx] = 1'b0;
            end
          end
          ihmt_pkg::CMD_QUERY: begin
            if (e_valid && (e_iface == cur.iface) && (e_timer == '0) &&
                (e_group != cfg.all_hosts_group)) begin
              mem_wr_en    = 1'b1;
              mem_wr_data  = {e_group, e_iface, draw};
              lfsr_next    = lfsr_step;
              running_next = 1'b1;
            end
          end
          ihmt_pkg::CMD_REPORT: begin
            if (e_match) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {e_group, e_iface, TIMER_BITS'(0)};
            end
          end
          default: begin
            if (e_valid && (e_timer != '0)) begin
              if (e_timer_dec == '0) begin
                if (hold_valid && !out_free) begin
                  stall = 1'b1;
                end else begin
                  if (hold_valid) begin
                    out_valid_next = 1'b1;
                    out_data_next  = make_res(1'b1, hold_group, hold_iface,
                                              ihmt_pkg::STAT_OK, 1'b0);
                  end
                  hold_valid_next = 1'b1;
                  hold_group_next = e_group;
                  hold_iface_next = e_iface;
                end
              end else begin
                running_next = 1'b1;
              end
              if (!stall) begin
                mem_wr_en   = 1'b1;
                mem_wr_data = {e_group, e_iface, e_timer_dec};
              end
            end
          end
        endcase
        if (!stall) begin
          if (idx == LAST_IDX) begin
            state_next = ihmt_pkg::S_DONE;
          end else begin
            idx_next    = idx + AW'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx + AW'(1);
          end
        end
      end

      ihmt_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = ihmt_pkg::S_IDLE;
          out_data_next  = make_res(1'b0, '0, '0, status_q, 1'b1);
          case (cur.command)
            ihmt_pkg::CMD_JOIN: begin
              if (found) begin
                out_data_next = make_res(1'b0, '0, '0, ihmt_pkg::STAT_OK, 1'b1);
              end else if (!free_found) begin
                out_data_next = make_res(1'b0, '0, '0, ihmt_pkg::STAT_FULL, 1'b1);
              end else begin
                valid_next[free_idx] = 1'b1;
                mem_wr_en   = 1'b1;
                mem_wr_addr = free_idx;
                mem_wr_data = {cur.group_addr, cur.iface, TIMER_BITS'(0)};
                if (cur.group_addr == cfg.all_hosts_group) begin
                  out_data_next = make_res(1'b0, '0, '0, ihmt_pkg::STAT_OK, 1'b1);
                end else if (cur.iface == cfg.loopback_iface) begin
                  out_data_next = make_res(1'b0, '0, '0, ihmt_pkg::STAT_LOOPBACK, 1'b1);
                end else begin
                  mem_wr_data   = {cur.group_addr, cur.iface, draw};
                  lfsr_next     = lfsr_step;
                  running_next  = 1'b1;
                  out_data_next = make_res(1'b1, cur.group_addr, cur.iface,
                                           ihmt_pkg::STAT_OK, 1'b1);
                end
              end
            end
            ihmt_pkg::CMD_LEAVE: begin
              out_data_next = make_res(1'b0, '0, '0,
                                       found ? ihmt_pkg::STAT_OK : ihmt_pkg::STAT_NOT_FOUND,
                                       1'b1);
            end
            ihmt_pkg::CMD_TICK: begin
              if (hold_valid) begin
                out_data_next = make_res(1'b1, hold_group, hold_iface,
                                         ihmt_pkg::STAT_OK, 1'b1);
              end
            end
            default: ;
          endcase
        end
      end

      default: state_next = ihmt_pkg::S_IDLE;
    endcase

    if (cfg.seed_load) begin
      lfsr_next = (cfg.seed_value == '0) ? ihmt_pkg::SEED_BITS'(1) : cfg.seed_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ihmt_pkg::S_IDLE;
      running    <= 1'b0;
      lfsr       <= ihmt_pkg::SEED_RESET;
      valid_bits <= '0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state      <= state_next;
      running    <= running_next;
      lfsr       <= lfsr_next;
      valid_bits <= valid_next;
      out_valid  <= out_valid_next;
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    status_q   <= status_next;
    idx        <= idx_next;
    free_idx   <= free_idx_next;
    found      <= found_next;
    free_found <= free_found_next;
    hold_group <= hold_group_next;
    hold_iface <= hold_iface_next;
    out_data   <= out_data_next;
  end

endmodule

/* sv/igmp_host_membership_timers_unit.sv */
// ----------------------------------------------------------------------------
// igmp_host_membership_timers_unit
// IGMPv1 host membership table with per-group report timers.
// ----------------------------------------------------------------------------
// An item that walks the table (join, leave, a valid query or report, or a
// tick while timers run) reads one entry at a time through the single read
// port of the entry memory, between an accept step and a finish step; any
// other item goes from accept straight to finish. A result held back on the
// result channel stalls the item. Entries are valid only after a join, so no
// clearing pass follows reset.
module igmp_host_membership_timers_unit #(
  parameter int TABLE_DEPTH = ihmt_pkg::TABLE_DEPTH_DEFAULT,
  parameter int TIMER_BITS  = ihmt_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ihmt_pkg::ADDR_BITS-1:0] paddr,
  input  logic [ihmt_pkg::DATA_BITS-1:0] pwdata,
  output logic [ihmt_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  ihmt_pkg::cmd_t                 cmd,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ihmt_pkg::res_t                 res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = ihmt_pkg::GROUP_BITS + ihmt_pkg::IFACE_BITS + TIMER_BITS;

  ihmt_pkg::cfg_t cfg;
  logic           mem_wr_en;
  logic [AW-1:0]  mem_wr_addr;
  logic [EW-1:0]  mem_wr_data;
  logic           mem_rd_en;
  logic [AW-1:0]  mem_rd_addr;
  logic [EW-1:0]  mem_rd_data;

  ihmt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ihmt_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ihmt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIMER_BITS  (TIMER_BITS),
    .AW          (AW),
    .EW          (EW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule
